/* sv/ccr_pkg.sv */
// ccr_pkg: shared types, codes and constants of the CAN command reassembler
// used by ccr_cfg_regs and can_command_reassembler_unit; no dependencies
`timescale 1ns / 1ps

package ccr_pkg;

  // fixed field widths
  localparam int CNT_W       = 10;
  localparam int TOTAL_W     = 17;
  localparam int DLC_W       = 4;
  localparam int ID_W        = 11;
  localparam int IDX_W       = 9;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int MAX_DLC     = 8;
  localparam int DLC_SEL_W   = 3;
  localparam int HDR_BYTES   = 4;
  localparam int FRAME_OVHD  = 7;
  localparam int BUF_DEPTH_DEF = 512;

  // stream packing
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 24;
  localparam int DLC_LSB     = 11;
  localparam int DATA_LSB    = 15;
  localparam int IDX_LSB     = 79;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [10:0] RST_RX_CAN_ID   = 11'd0;
  localparam logic [9:0]  RST_BUFFER_SIZE = 10'd512;
  localparam logic [7:0]  RST_SOP_BYTE    = 8'd1;
  localparam logic [7:0]  RST_EOP_BYTE    = 8'd23;
  localparam logic [7:0]  RST_ERASE_OP    = 8'd52;
  localparam logic [7:0]  RST_PROGRAM_OP  = 8'd57;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RX_CAN_ID   = 3'd0,
    REG_BUFFER_SIZE = 3'd1,
    REG_SOP_BYTE    = 3'd2,
    REG_EOP_BYTE    = 3'd3,
    REG_ERASE_OP    = 3'd4,
    REG_PROGRAM_OP  = 3'd5
  } cfg_reg_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_FRAME   = 2'd0,
    REQ_RESTART = 2'd1,
    REQ_READ    = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_COLLECT  = 3'd0,
    ST_DONE     = 3'd1,
    ST_BADDATA  = 3'd2,
    ST_BADPARAM = 3'd3,
    ST_IGNORED  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_POST,
    S_CHECK,
    S_RDATA,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [10:0] rx_can_id;
    logic [9:0]  buffer_size;
    logic [7:0]  sop_byte;
    logic [7:0]  eop_byte;
    logic [7:0]  erase_op;
    logic [7:0]  program_op;
  } cfg_t;

endpackage

/* sv/ccr_cfg_regs.sv */
// ccr_cfg_regs: configuration register file of the command reassembler
// depends on ccr_pkg for the register indexes, reset values and cfg_t
`timescale 1ns / 1ps

module ccr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ccr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ccr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ccr_pkg::cfg_t                 cfg_o
);
  import ccr_pkg::*;

  cfg_t cfg_q;

  // writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register writes, out-of-range indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rx_can_id   <= RST_RX_CAN_ID;
      cfg_q.buffer_size <= RST_BUFFER_SIZE;
      cfg_q.sop_byte    <= RST_SOP_BYTE;
      cfg_q.eop_byte    <= RST_EOP_BYTE;
      cfg_q.erase_op    <= RST_ERASE_OP;
      cfg_q.program_op  <= RST_PROGRAM_OP;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_RX_CAN_ID:   cfg_q.rx_can_id   <= cfg_data_i[10:0];
        REG_BUFFER_SIZE: cfg_q.buffer_size <= cfg_data_i[9:0];
        REG_SOP_BYTE:    cfg_q.sop_byte    <= cfg_data_i[7:0];
        REG_EOP_BYTE:    cfg_q.eop_byte    <= cfg_data_i[7:0];
        REG_ERASE_OP:    cfg_q.erase_op    <= cfg_data_i[7:0];
        REG_PROGRAM_OP:  cfg_q.program_op  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/can_command_reassembler_unit.sv */
// A restart or ignored frame goes from accept through S_FIN to the output register, a read
// through S_RDATA and S_FIN, an appended frame through S_WRITE once per byte, then S_POST
// (and S_CHECK when it completes the command) and S_FIN; S_FIN waits for a free output.
// One item at a time; the single write port of the command store takes one byte a cycle.
// Reset (rst_ni, async low) clears count, length and armed state and the control registers;
// the command store is not cleared, entries at or beyond the count read as zero.
`timescale 1ns / 1ps

module can_command_reassembler_unit #(
  parameter int BUF_DEPTH = ccr_pkg::BUF_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave tdata: can_id, dlc, data0..data7, byte_index; tuser: req_type
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ccr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [ccr_pkg::REQ_W-1:0]       s_axis_tuser,
  // master tdata: ack_echo, stop_for_flash, byte_count, read_byte, zero pad; tuser: status
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ccr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [ccr_pkg::STATUS_W-1:0]    m_axis_tuser,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ccr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ccr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ccr_pkg::*;

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [CNT_W-1:0] SIZE_CAP =
    (BUF_DEPTH > (2**CNT_W) - 1) ? {CNT_W{1'b1}} : CNT_W'(BUF_DEPTH);

  cfg_t cfg;

  ccr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // control state
  state_e              state_q, state_d;
  logic [CNT_W-1:0]    held_q, held_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic                known_q, known_d;
  logic                armed_q, armed_d;
  logic [DLC_SEL_W-1:0] wr_cnt_q, wr_cnt_d;
  logic                m_valid_q, m_valid_d;

  // payload registers
  logic [DLC_W-1:0]    dlc_q, dlc_d;
  logic [7:0]          data_q [MAX_DLC];
  logic                data_ld;
  logic [7:0]          hdr_q [HDR_BYTES];
  logic                rd_hit_q, rd_hit_d;
  status_e             res_status_q, res_status_d;
  logic                res_ack_q, res_ack_d;
  logic                res_stop_q, res_stop_d;
  logic [7:0]          res_rbyte_q, res_rbyte_d;
  logic [OUT_TDATA_W-1:0] m_tdata_q;
  logic [STATUS_W-1:0] m_tuser_q;

  // command store
  logic [7:0]          store_q [BUF_DEPTH];
  logic [7:0]          rd_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [7:0]          mem_wdata;

  // unpacked input fields
  logic [ID_W-1:0]     in_can_id;
  logic [DLC_W-1:0]    in_dlc;
  logic [IDX_W-1:0]    in_idx;
  logic [7:0]          in_data [MAX_DLC];

  assign in_can_id = s_axis_tdata[ID_W-1:0];
  assign in_dlc    = s_axis_tdata[DLC_LSB +: DLC_W];
  assign in_idx    = s_axis_tdata[IDX_LSB +: IDX_W];

  always_comb begin
    for (int k = 0; k < MAX_DLC; k++) begin
      in_data[DLC_SEL_W'(k)] = s_axis_tdata[DATA_LSB + 8*k +: 8];
    end
  end

  // shared conditions
  logic                acc, frame_hit, overflow, wr_last, out_free, complete;
  logic                known_n;
  logic [TOTAL_W-1:0]  total_n;
  logic [DLC_W-1:0]    dlc_c;
  logic [CNT_W-1:0]    eff_size, wr_pos;
  logic [CNT_W:0]      fill_sum;

  assign s_axis_tready = (state_q == S_IDLE);
  assign acc       = s_axis_tvalid & s_axis_tready;
  assign eff_size  = (cfg.buffer_size > SIZE_CAP) ? SIZE_CAP : cfg.buffer_size;
  assign dlc_c     = (in_dlc > DLC_W'(MAX_DLC)) ? DLC_W'(MAX_DLC) : in_dlc;
  assign fill_sum  = {1'b0, held_q} + (CNT_W+1)'(dlc_c);
  assign overflow  = fill_sum > {1'b0, eff_size};
  assign frame_hit = (s_axis_tuser == REQ_FRAME) && armed_q &&
                     (in_can_id == cfg.rx_can_id);
  assign wr_pos    = held_q + CNT_W'(wr_cnt_q);
  assign wr_last   = ({1'b0, wr_cnt_q} == (dlc_q - DLC_W'(1)));
  assign out_free  = !m_valid_q || m_axis_tready;

  // length becomes known once the header is in
  assign known_n  = known_q || (held_q >= CNT_W'(HDR_BYTES));
  assign total_n  = (!known_q && (held_q >= CNT_W'(HDR_BYTES))) ?
                    TOTAL_W'(FRAME_OVHD) + TOTAL_W'({hdr_q[3], hdr_q[2]}) : total_q;
  assign complete = known_n && (TOTAL_W'(held_q) == total_n);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (req_e'(s_axis_tuser))
            REQ_FRAME: begin
              if (frame_hit && !overflow) begin
                state_d = (dlc_c == '0) ? S_POST : S_WRITE;
              end else begin
                state_d = S_FIN;
              end
            end
            REQ_READ: state_d = S_RDATA;
            default:  state_d = S_FIN;
          endcase
        end
      end
      S_WRITE: state_d = wr_last ? S_POST : S_WRITE;
      S_POST:  state_d = complete ? S_CHECK : S_FIN;
      S_CHECK: state_d = S_FIN;
      S_RDATA: state_d = S_FIN;
      S_FIN:   state_d = out_free ? S_IDLE : S_FIN;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    held_d       = held_q;
    total_d      = total_q;
    known_d      = known_q;
    armed_d      = armed_q;
    wr_cnt_d     = wr_cnt_q;
    dlc_d        = dlc_q;
    data_ld      = 1'b0;
    rd_hit_d     = rd_hit_q;
    res_status_d = res_status_q;
    res_ack_d    = res_ack_q;
    res_stop_d   = res_stop_q;
    res_rbyte_d  = res_rbyte_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = AW'(wr_pos);
    mem_wdata    = data_q[wr_cnt_q];
    mem_raddr    = AW'(in_idx);
    m_valid_d    = m_valid_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          res_status_d = ST_IGNORED;
          res_ack_d    = 1'b0;
          res_stop_d   = 1'b0;
          res_rbyte_d  = '0;
          case (req_e'(s_axis_tuser))
            REQ_RESTART: begin
              held_d  = '0;
              total_d = '0;
              known_d = 1'b0;
              if (eff_size < CNT_W'(MAX_DLC)) begin
                armed_d      = 1'b0;
                res_status_d = ST_BADPARAM;
              end else begin
                armed_d      = 1'b1;
                res_status_d = ST_COLLECT;
              end
            end
            REQ_READ: begin
              rd_hit_d = ({1'b0, in_idx} < held_q);
              mem_re   = 1'b1;
            end
            REQ_FRAME: begin
              if (frame_hit) begin
                if (overflow) begin
                  res_status_d = ST_BADDATA;
                  armed_d      = 1'b0;
                end else begin
                  dlc_d    = dlc_c;
                  data_ld  = 1'b1;
                  wr_cnt_d = '0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_WRITE: begin
        mem_we   = 1'b1;
        wr_cnt_d = wr_cnt_q + DLC_SEL_W'(1);
        if (wr_last) begin
          held_d = held_q + CNT_W'(dlc_q);
        end
      end
      S_POST: begin
        known_d      = known_n;
        total_d      = total_n;
        res_ack_d    = 1'b1;
        res_status_d = ST_COLLECT;
        if (complete) begin
          armed_d   = 1'b0;
          mem_re    = 1'b1;
          mem_raddr = AW'(held_q - CNT_W'(1));
        end
      end
      S_CHECK: begin
        if ((hdr_q[0] == cfg.sop_byte) && (rd_q == cfg.eop_byte)) begin
          res_status_d = ST_DONE;
          res_stop_d   = (hdr_q[1] == cfg.erase_op) || (hdr_q[1] == cfg.program_op);
        end else begin
          res_status_d = ST_BADDATA;
        end
      end
      S_RDATA: begin
        res_rbyte_d = rd_hit_q ? rd_q : 8'd0;
      end
      S_FIN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      held_q    <= '0;
      total_q   <= '0;
      known_q   <= 1'b0;
      armed_q   <= 1'b0;
      wr_cnt_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      total_q   <= total_d;
      known_q   <= known_d;
      armed_q   <= armed_d;
      wr_cnt_q  <= wr_cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers and header snoop
  always_ff @(posedge clk_i) begin
    dlc_q        <= dlc_d;
    rd_hit_q     <= rd_hit_d;
    res_status_q <= res_status_d;
    res_ack_q    <= res_ack_d;
    res_stop_q   <= res_stop_d;
    res_rbyte_q  <= res_rbyte_d;
    if (data_ld) begin
      for (int k = 0; k < MAX_DLC; k++) begin
        data_q[DLC_SEL_W'(k)] <= in_data[DLC_SEL_W'(k)];
      end
    end
    if (mem_we && (wr_pos < CNT_W'(HDR_BYTES))) begin
      hdr_q[wr_pos[1:0]] <= mem_wdata;
    end
    if ((state_q == S_FIN) && out_free) begin
      m_tdata_q <= {4'd0, res_rbyte_q, held_q, res_stop_q, res_ack_q};
      m_tuser_q <= res_status_q;
    end
  end

  // command store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= store_q[mem_raddr];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

`ifndef ASSERT_OFF
  // count never runs past the store
  a_held_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= SIZE_CAP)
    else $error("byte count beyond store size");

  // every store write lands inside the usable buffer
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (wr_pos < eff_size))
    else $error("store write beyond buffer size");

  // a known length implies the header has been taken
  a_known_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    known_q |-> (held_q >= CNT_W'(HDR_BYTES)))
    else $error("length known before header held");

  // the end check only follows a count that met the total
  a_check_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (known_q && (TOTAL_W'(held_q) == total_q) && !armed_q))
    else $error("end check without matching count");
`endif

endmodule
